/* src/gcc_pkg.sv */
package gcc_pkg;

  // Width of one coin value register.
  localparam int VALUE_BITS = 16;

  // Width of the active coin count register.
  localparam int ACTIVE_BITS = 3;

  // Largest number of coin slots that the block supports.
  localparam int MAX_COINS = 8;

  // Coin values after reset; slots past the fourth start unused.
  localparam logic [VALUE_BITS-1:0] RESET_VALUES [MAX_COINS] = '{
    16'd10, 16'd5, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // Active coin count after reset, before it is limited to the slot count.
  localparam int ACTIVE_RESET = 4;

endpackage

/* src/greedy_coin_change_unit.sv */
// Throughput: one request per cycle while the output does not stall; each pipeline
// stage does one restoring divide step (one shift, subtract and compare), and each
// coin uses AMOUNT_BITS stages in a row.
// A stalled output holds its result while empty stages ahead of it keep filling.
// Reset (rst, synchronous, active high) empties the pipeline and sets the coin values
// to 10, 5, 2, 1 (zero for further slots) with four coins active.
module greedy_coin_change_unit #(
  parameter int NUM_COINS   = 4,
  parameter int AMOUNT_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // Configuration write port.
  input  logic                                          wr_en,
  input  logic [$clog2(NUM_COINS+1)-1:0]                wr_index,
  input  logic [gcc_pkg::VALUE_BITS-1:0]                wr_data,
  // Input stream. s_tdata fields from bit 0: amount.
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [8*((AMOUNT_BITS+7)/8)-1:0]              s_tdata,
  // Output stream. m_tdata fields from bit 0: count_0 .. count_N-1, leftover.
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  output logic [8*(((NUM_COINS+1)*AMOUNT_BITS+7)/8)-1:0] m_tdata
);
  import gcc_pkg::*;

  localparam int W        = AMOUNT_BITS;
  localparam int STAGES   = NUM_COINS * AMOUNT_BITS;
  localparam int IDX_BITS = $clog2(NUM_COINS+1);
  localparam int CMP_BITS = ((W > VALUE_BITS) ? W : VALUE_BITS) + 1;
  localparam int OUT_BITS = 8*(((NUM_COINS+1)*AMOUNT_BITS+7)/8);
  localparam int PAY_BITS = (NUM_COINS+1)*AMOUNT_BITS;
  localparam logic [IDX_BITS-1:0] REG_ACTIVE = IDX_BITS'(NUM_COINS);
  localparam logic [3:0] SLOTS = 4'(NUM_COINS);
  localparam logic [ACTIVE_BITS-1:0] ACTIVE_INIT =
    ACTIVE_BITS'((ACTIVE_RESET < NUM_COINS) ? ACTIVE_RESET : NUM_COINS);

  // Configuration registers.
  logic [VALUE_BITS-1:0]  coin_value [NUM_COINS];
  logic [ACTIVE_BITS-1:0] active_coins;
  logic [3:0]             used;
  logic [NUM_COINS-1:0]   coin_use;

  // Pipeline stage registers.
  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] ready;
  logic [W-1:0]      rest_q [STAGES];
  logic [W-1:0]      part_q [STAGES];
  logic [W-1:0]      quo_q  [STAGES];
  logic [W-1:0]      cnt_q  [STAGES][NUM_COINS];

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COINS; k++) begin
        coin_value[k] <= RESET_VALUES[k];
      end
      active_coins <= ACTIVE_INIT;
    end else if (wr_en) begin
      for (int k = 0; k < NUM_COINS; k++) begin
        if (wr_index == IDX_BITS'(k)) begin
          coin_value[k] <= wr_data;
        end
      end
      if (wr_index == REG_ACTIVE) begin
        active_coins <= wr_data[ACTIVE_BITS-1:0];
      end
    end
  end

  // A coin takes part when it lies within the active count and is nonzero.
  always_comb begin
    used = ({1'b0, active_coins} > SLOTS) ? SLOTS : {1'b0, active_coins};
    for (int k = 0; k < NUM_COINS; k++) begin
      coin_use[k] = (4'(k) < used) && (coin_value[k] != '0);
    end
  end

  assign s_tready = ready[0];

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      localparam int K = s / W;
      localparam int J = s % W;

      logic               src_valid;
      logic [W-1:0]       src_rest;
      logic [W-1:0]       src_part;
      logic [W-1:0]       src_quo;
      logic [W-1:0]       src_cnt [NUM_COINS];
      logic [W-1:0]       nxt_rest;
      logic [W-1:0]       nxt_part;
      logic [W-1:0]       nxt_quo;
      logic [W-1:0]       nxt_cnt [NUM_COINS];
      logic [CMP_BITS-1:0] shifted;
      logic [CMP_BITS-1:0] divisor;
      logic [CMP_BITS-1:0] diff;
      logic                fits;

      // Source of this stage: the input port or the previous stage.
      if (s == 0) begin : g_src_in
        assign src_valid = s_tvalid;
        assign src_rest  = s_tdata[W-1:0];
        assign src_part  = '0;
        assign src_quo   = s_tdata[W-1:0];
        always_comb begin
          for (int k = 0; k < NUM_COINS; k++) begin
            src_cnt[k] = '0;
          end
        end
      end else begin : g_src_prev
        assign src_valid = valid[s-1];
        assign src_rest  = rest_q[s-1];
        // The first step of a coin starts a fresh division of the remaining amount.
        assign src_part  = (J == 0) ? '0 : part_q[s-1];
        assign src_quo   = (J == 0) ? rest_q[s-1] : quo_q[s-1];
        assign src_cnt   = cnt_q[s-1];
      end

      // Hand-off: a stage can load when it is empty or its successor moves on.
      if (s == STAGES-1) begin : g_rdy_out
        assign ready[s] = ~valid[s] | m_tready;
      end else begin : g_rdy_mid
        assign ready[s] = ~valid[s] | ready[s+1];
      end

      // One restoring divide step: bring in the next dividend bit and try the subtract.
      always_comb begin
        shifted  = CMP_BITS'({src_part, src_quo[W-1]});
        divisor  = CMP_BITS'(coin_value[K]);
        diff     = shifted - divisor;
        fits     = (shifted >= divisor);
        nxt_part = fits ? diff[W-1:0] : shifted[W-1:0];
        nxt_quo  = {src_quo[W-2:0], fits};
        nxt_rest = src_rest;
        nxt_cnt  = src_cnt;
        // The last step of a coin settles its count and the remainder passed on.
        if (J == W-1) begin
          if (coin_use[K]) begin
            nxt_cnt[K] = nxt_quo;
            nxt_rest   = nxt_part;
          end else begin
            nxt_cnt[K] = '0;
          end
        end
      end

      // Stage valid bit.
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[s] <= 1'b0;
        end else if (ready[s]) begin
          valid[s] <= src_valid;
        end
      end

      // Stage payload.
      always_ff @(posedge clk) begin
        if (ready[s] && src_valid) begin
          rest_q[s] <= nxt_rest;
          part_q[s] <= nxt_part;
          quo_q[s]  <= nxt_quo;
          cnt_q[s]  <= nxt_cnt;
        end
      end
    end
  endgenerate

  // Result packing from the last stage.
  assign m_tvalid = valid[STAGES-1];

  genvar c;
  generate
    for (c = 0; c < NUM_COINS; c++) begin : g_out
      assign m_tdata[c*W +: W] = cnt_q[STAGES-1][c];
    end
    if (OUT_BITS > PAY_BITS) begin : g_pad
      assign m_tdata[OUT_BITS-1:PAY_BITS] = '0;
    end
  endgenerate
  assign m_tdata[NUM_COINS*W +: W] = rest_q[STAGES-1];

  // An accepted request lands in the first stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> valid[0])
    else $error("accepted request did not reach the first stage");

  // An empty first stage always takes a request.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !valid[0] |-> s_tready)
    else $error("input stalled with an empty first stage");

  // A full pipeline with a stalled output pushes back on the input.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && !m_tready) |-> !s_tready)
    else $error("input accepted into a full, stalled pipeline");

  // After the first divide step the partial remainder is a single bit.
  a_first_part: assert property (@(posedge clk) disable iff (rst)
    valid[0] |-> (part_q[0][W-1:1] == '0))
    else $error("first stage partial remainder out of range");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  import gcc_pkg::*;

  localparam int NUM_COINS     = 4;
  localparam int AMOUNT_BITS   = 16;
  localparam int IDX_BITS      = $clog2(NUM_COINS + 1);
  localparam int COIN_IDX_BITS = $clog2(NUM_COINS);

  // Register map: coin values first, then the active coin count.
  localparam logic [IDX_BITS-1:0] REG_COIN_FIRST = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_ACTIVE     = IDX_BITS'(NUM_COINS);

  localparam int DRAIN_CYCLES = NUM_COINS * AMOUNT_BITS + 16;
  localparam int MAX_REPORTS  = 10;

  // One result as it appears on m_tdata: counts from bit 0, leftover on top.
  typedef struct packed {
    logic [AMOUNT_BITS-1:0]                leftover;
    logic [NUM_COINS-1:0][AMOUNT_BITS-1:0] count;
  } change_t;

  // Holds the coin setup and the splits still owed by the block.
  class change_scoreboard;
    logic [VALUE_BITS-1:0]  coin_value [NUM_COINS];
    logic [ACTIVE_BITS-1:0] active_coins;
    change_t                owed_splits [$];
    int                     failures;

    function new();
      for (int k = 0; k < NUM_COINS; k++) coin_value[k] = RESET_VALUES[k];
      active_coins = ACTIVE_BITS'((ACTIVE_RESET < NUM_COINS) ? ACTIVE_RESET : NUM_COINS);
      failures     = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped by the block.
    function void write_reg(logic [IDX_BITS-1:0] index, logic [VALUE_BITS-1:0] data);
      if (index < REG_ACTIVE) coin_value[index[COIN_IDX_BITS-1:0]] = data;
      else if (index == REG_ACTIVE) active_coins = data[ACTIVE_BITS-1:0];
    endfunction

    // Greedy split in register order; zero or inactive coins take nothing.
    function change_t split_amount(logic [AMOUNT_BITS-1:0] amount);
      change_t                split;
      logic [AMOUNT_BITS-1:0] rest;
      int                     used;
      split = '0;
      rest  = amount;
      used  = (active_coins > NUM_COINS) ? NUM_COINS : int'(active_coins);
      for (int k = 0; k < NUM_COINS; k++) begin
        if (k < used && coin_value[k] != 0) begin
          split.count[k] = rest / coin_value[k];
          rest           = rest % coin_value[k];
        end
      end
      split.leftover = rest;
      return split;
    endfunction

    function void note_request(logic [AMOUNT_BITS-1:0] amount);
      owed_splits.push_back(split_amount(amount));
    endfunction

    function void report(string field, logic [AMOUNT_BITS-1:0] expected,
                         logic [AMOUNT_BITS-1:0] actual);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, expected, actual);
    endfunction

    function void check_result(change_t got);
      change_t want;
      if (owed_splits.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: %h", $realtime, got);
        return;
      end
      want = owed_splits.pop_front();
      for (int k = 0; k < NUM_COINS; k++)
        if (got.count[k] !== want.count[k])
          report($sformatf("count_%0d", k), want.count[k], got.count[k]);
      if (got.leftover !== want.leftover) report("leftover", want.leftover, got.leftover);
    endfunction

    function int pending();
      return owed_splits.size();
    endfunction
  endclass

  logic                                           clk = 1'b0;
  logic                                           rst = 1'b1;
  logic                                           wr_en = 1'b0;
  logic [IDX_BITS-1:0]                            wr_index = '0;
  logic [VALUE_BITS-1:0]                          wr_data = '0;
  logic                                           s_tvalid = 1'b0;
  logic                                           s_tready;
  logic [8*((AMOUNT_BITS+7)/8)-1:0]               s_tdata = '0;
  logic                                           m_tvalid;
  logic                                           m_tready = 1'b0;
  logic [8*(((NUM_COINS+1)*AMOUNT_BITS+7)/8)-1:0] m_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  change_scoreboard sb = new();

  greedy_coin_change_unit #(
    .NUM_COINS  (NUM_COINS),
    .AMOUNT_BITS(AMOUNT_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  // Receiver backpressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watch both streams; values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata[AMOUNT_BITS-1:0]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata[$bits(change_t)-1:0]);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mix of full-range, small, near-top and power-of-two amounts.
  function automatic logic [AMOUNT_BITS-1:0] pick_amount();
    case ($urandom_range(3))
      0: return AMOUNT_BITS'($urandom);
      1: return AMOUNT_BITS'($urandom_range(255));
      2: return AMOUNT_BITS'(16'hFFFF - $urandom_range(255));
      default: return AMOUNT_BITS'((16'd1 << $urandom_range(15)) + $urandom_range(3));
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_coin();
    case ($urandom_range(4))
      0: return '0;
      1: return VALUE_BITS'($urandom_range(1, 16));
      2: return VALUE_BITS'($urandom_range(17, 1000));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Register writes are back to back; the caller lowers wr_en afterwards.
  task automatic write_reg(input logic [IDX_BITS-1:0] index, input logic [VALUE_BITS-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    sb.write_reg(index, data);
    @(posedge clk);
  endtask

  // Load all coin values and the active count, plus one write to an unused index.
  task automatic program_coins(input logic [VALUE_BITS-1:0] v0, input logic [VALUE_BITS-1:0] v1,
                               input logic [VALUE_BITS-1:0] v2, input logic [VALUE_BITS-1:0] v3,
                               input logic [VALUE_BITS-1:0] active);
    write_reg(REG_COIN_FIRST + IDX_BITS'(0), v0);
    write_reg(REG_COIN_FIRST + IDX_BITS'(1), v1);
    write_reg(REG_COIN_FIRST + IDX_BITS'(2), v2);
    write_reg(REG_COIN_FIRST + IDX_BITS'(3), v3);
    write_reg(REG_ACTIVE + IDX_BITS'($urandom_range(1, 3)), VALUE_BITS'($urandom));
    write_reg(REG_ACTIVE, active);
    wr_en <= 1'b0;
  endtask

  // Offer one request, with a random gap before it, and wait for acceptance.
  task automatic send_amount(input logic [AMOUNT_BITS-1:0] amount);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= amount;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Both extremes of the amount first, then random requests.
  task automatic run_phase(input int count);
    send_amount('0);
    send_amount('1);
    for (int i = 0; i < count; i++) send_amount(pick_amount());
    drain();
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  localparam int PHASE_ITEMS = 57;

  initial begin
    logic [VALUE_BITS-1:0] coins [NUM_COINS];
    logic [VALUE_BITS-1:0] swap;
    logic [AMOUNT_BITS-1:0] directed [15] = '{
      16'd0, 16'd1, 16'd2, 16'd4, 16'd5, 16'd9, 16'd10, 16'd17, 16'd18,
      16'hFFFF, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset coin setup with directed amounts.
    set_idle(23, 53);
    foreach (directed[i]) send_amount(directed[i]);
    for (int i = 0; i < PHASE_ITEMS - 7; i++) send_amount(pick_amount());
    drain();

    // Largest coin values everywhere.
    program_coins(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4);
    run_phase(PHASE_ITEMS);
    // Single coin of one: the first count carries the whole amount.
    program_coins(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_phase(PHASE_ITEMS);
    // Every coin value zero: leftover is the amount.
    program_coins(16'd0, 16'd0, 16'd0, 16'd0, 16'd4);
    run_phase(PHASE_ITEMS);

    set_idle(53, 23);
    // No coins active.
    program_coins(16'd25, 16'd10, 16'd5, 16'd1, 16'd0);
    run_phase(PHASE_ITEMS);
    // Values out of order, active count above the slot count.
    program_coins(16'd3, 16'd7, 16'hFFFF, 16'd2, 16'd7);
    run_phase(PHASE_ITEMS);
    // Smallest active coin is not one, so a leftover remains.
    program_coins(16'd100, 16'd30, 16'd6, 16'd4, 16'd3);
    run_phase(PHASE_ITEMS);
    // Zero coin between active ones; junk above the active count bits.
    program_coins(16'd50, 16'd20, 16'd0, 16'd3, 16'hFFF5);
    run_phase(PHASE_ITEMS);

    // Random setups, mostly kept in descending order.
    set_idle(0, 0);
    for (int p = 0; p < 3; p++) begin
      foreach (coins[k]) coins[k] = pick_coin();
      if ($urandom_range(3) != 0) begin
        for (int a = 0; a < NUM_COINS - 1; a++)
          for (int b = 0; b < NUM_COINS - 1 - a; b++)
            if (coins[b] < coins[b+1]) begin
              swap       = coins[b];
              coins[b]   = coins[b+1];
              coins[b+1] = swap;
            end
      end
      program_coins(coins[0], coins[1], coins[2], coins[3],
                    VALUE_BITS'(($urandom & 16'hFFF8) | $urandom_range(7)));
      run_phase(PHASE_ITEMS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
